// ===== rtl/core/apsel_pkg.sv =====
// package: shared types, constants and helper functions for the partition selector
`timescale 1ns / 1ps

package apsel_pkg;

  localparam int unsigned SeedW  = 10;
  localparam int unsigned CntW   = 3;
  localparam int unsigned CoordW = 4;
  localparam int unsigned SumW   = 6;
  localparam int unsigned PartW  = 2;

  // hash multiplier
  localparam logic [31:0] HashMul = 32'hEEDE0891;

  // shift amounts applied to the squared nibbles
  localparam logic [2:0] ShNarrow = 3'd4;
  localparam logic [2:0] ShMid    = 3'd5;
  localparam logic [2:0] ShWide   = 3'd6;

  // partition counts: three selects the wide shift; sums are cleared below three and below four
  localparam logic [CntW-1:0] CntThree = 3'd3;
  localparam logic [CntW-1:0] CntFour  = 3'd4;

  // one texel transaction as it arrives
  typedef struct packed {
    logic [CoordW-1:0] z;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
    logic [CntW-1:0]   cnt;
    logic [SeedW-1:0]  seed;
  } item_t;

  // per-texel controls carried beside the hash
  typedef struct packed {
    logic [CntW-1:0]   cnt;
    logic              seed0;
    logic              seed1;
    logic              seed4;
    logic [CoordW:0]   x;
    logic [CoordW:0]   y;
    logic [CoordW:0]   z;
  } ctl_t;

  // hash stage result
  typedef struct packed {
    logic        valid;
    logic [31:0] r;
    ctl_t        ctl;
  } hash_t;

  // weighted sums stage result
  typedef struct packed {
    logic            valid;
    logic [SumW-1:0] a;
    logic [SumW-1:0] b;
    logic [SumW-1:0] c;
    logic [SumW-1:0] d;
  } sums_t;

  // square a nibble, keep the low byte, shift right
  function automatic logic [3:0] sq_shift(input logic [3:0] nib, input logic [2:0] sh);
    logic [7:0] sq;
    logic [7:0] shifted;
    sq      = 8'(nib) * 8'(nib);
    shifted = sq >> sh;
    return shifted[3:0];
  endfunction

  // shifted square times a coordinate, modulo 64
  function automatic logic [SumW-1:0] weight(input logic [3:0] nib, input logic [2:0] sh,
                                             input logic [CoordW:0] coord);
    logic [3:0] s;
    logic [8:0] p;
    s = sq_shift(nib, sh);
    p = 9'(s) * 9'(coord);
    return p[SumW-1:0];
  endfunction

endpackage

// ===== rtl/core/apsel_hash.sv =====
// module: two-stage seed hash (xor-shift and multiply, then xor-shift and add mixing)
`timescale 1ns / 1ps

module apsel_hash (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_valid_i,
  input  apsel_pkg::item_t  in_i,
  input  logic              small_mode_i,
  output apsel_pkg::hash_t  out_o
);
  import apsel_pkg::*;

  logic        a_valid_d, a_valid_q;
  logic [31:0] a_prod_d, a_prod_q;
  ctl_t        a_ctl_d, a_ctl_q;
  logic [31:0] key;
  logic [31:0] v0;
  logic [CntW-1:0] cnt_m1;

  logic        b_valid_q;
  logic [31:0] b_r_d, b_r_q;
  ctl_t        b_ctl_q;
  logic [31:0] v1, v2, v3, v4, v5;

  // stage a: key offset by count, first xor-shift and multiply, coordinates doubled in small mode
  always_comb begin
    cnt_m1    = in_i.cnt - 3'd1;
    key       = {19'd0, cnt_m1, in_i.seed};
    v0        = key ^ (key >> 15);
    a_prod_d  = v0 * HashMul;
    a_valid_d = in_valid_i;
    a_ctl_d.cnt   = in_i.cnt;
    a_ctl_d.seed0 = in_i.seed[0];
    a_ctl_d.seed1 = in_i.seed[1];
    a_ctl_d.seed4 = in_i.seed[4];
    a_ctl_d.x     = small_mode_i ? {in_i.x, 1'b0} : {1'b0, in_i.x};
    a_ctl_d.y     = small_mode_i ? {in_i.y, 1'b0} : {1'b0, in_i.y};
    a_ctl_d.z     = small_mode_i ? {in_i.z, 1'b0} : {1'b0, in_i.z};
  end

  // stage b: remaining mixing steps
  always_comb begin
    v1    = a_prod_q ^ (a_prod_q >> 5);
    v2    = v1 + (v1 << 16);
    v3    = v2 ^ (v2 >> 7);
    v4    = v3 ^ (v3 >> 3);
    v5    = v4 ^ (v4 << 6);
    b_r_d = v5 ^ (v5 >> 17);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= a_valid_d;
      b_valid_q <= a_valid_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_prod_q <= a_prod_d;
      a_ctl_q  <= a_ctl_d;
      b_r_q    <= b_r_d;
      b_ctl_q  <= a_ctl_q;
    end
  end

  assign out_o.valid = b_valid_q;
  assign out_o.r     = b_r_q;
  assign out_o.ctl   = b_ctl_q;

`ifndef SYNTHESIS
  // an entering transaction reaches the stage b output through the stage a and stage b registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && in_valid_i) ##1 en_i |=> out_o.valid)
    else $error("apsel_hash: transaction lost between hash stages");
`endif

endmodule

// ===== rtl/core/apsel_weigh.sv =====
// module: shifted squared nibbles weight the coordinates into four 6-bit sums
`timescale 1ns / 1ps

module apsel_weigh (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  apsel_pkg::hash_t  hash_i,
  output apsel_pkg::sums_t  sums_o
);
  import apsel_pkg::*;

  logic [31:0]     r;
  logic [2:0]      wide, bit1, sa, sb, sc;
  logic [3:0]      nib_b_z;
  logic [SumW-1:0] a_d, b_d, c_d, d_d;
  logic            valid_q;
  logic [SumW-1:0] a_q, b_q, c_q, d_q;

  // shift selection from seed bits and count
  always_comb begin
    r    = hash_i.r;
    wide = (hash_i.ctl.cnt == CntThree) ? ShWide : ShMid;
    bit1 = hash_i.ctl.seed1 ? ShNarrow : ShMid;
    sa   = hash_i.ctl.seed0 ? bit1 : wide;
    sb   = hash_i.ctl.seed0 ? wide : bit1;
    sc   = hash_i.ctl.seed4 ? sa : sb;
  end

  // the four sums modulo 64, unused ones cleared
  always_comb begin
    nib_b_z = {r[1:0], r[31:30]};
    a_d = weight(r[3:0], sa, hash_i.ctl.x) + weight(r[7:4], sb, hash_i.ctl.y)
        + weight(r[29:26], sc, hash_i.ctl.z) + r[19:14];
    b_d = weight(r[11:8], sa, hash_i.ctl.x) + weight(r[15:12], sb, hash_i.ctl.y)
        + weight(nib_b_z, sc, hash_i.ctl.z) + r[15:10];
    c_d = weight(r[19:16], sa, hash_i.ctl.x) + weight(r[23:20], sb, hash_i.ctl.y)
        + weight(r[21:18], sc, hash_i.ctl.z) + r[11:6];
    d_d = weight(r[27:24], sa, hash_i.ctl.x) + weight(r[31:28], sb, hash_i.ctl.y)
        + weight(r[25:22], sc, hash_i.ctl.z) + r[7:2];
    if (hash_i.ctl.cnt < CntFour) begin
      d_d = '0;
    end
    if (hash_i.ctl.cnt < CntThree) begin
      c_d = '0;
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= hash_i.valid;
    end
  end

  // sum registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
      d_q <= d_d;
    end
  end

  assign sums_o.valid = valid_q;
  assign sums_o.a     = a_q;
  assign sums_o.b     = b_q;
  assign sums_o.c     = c_q;
  assign sums_o.d     = d_q;

`ifndef SYNTHESIS
  // a count below three leaves the third and fourth sums at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && hash_i.valid && hash_i.ctl.cnt < CntThree) |=> (sums_o.c == '0 && sums_o.d == '0))
    else $error("apsel_weigh: unused sums not cleared");
`endif

endmodule

// ===== rtl/core/apsel_pick.sv =====
// module: index of the largest sum, ties to the lower index, into the output register
`timescale 1ns / 1ps

module apsel_pick (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  apsel_pkg::sums_t           sums_i,
  output logic                       valid_o,
  output logic [apsel_pkg::PartW-1:0] part_o
);
  import apsel_pkg::*;

  logic [PartW-1:0] part_d, part_q;
  logic             valid_q;

  // priority compare
  always_comb begin
    if (sums_i.a >= sums_i.b && sums_i.a >= sums_i.c && sums_i.a >= sums_i.d) begin
      part_d = 2'd0;
    end else if (sums_i.b >= sums_i.c && sums_i.b >= sums_i.d) begin
      part_d = 2'd1;
    end else if (sums_i.c >= sums_i.d) begin
      part_d = 2'd2;
    end else begin
      part_d = 2'd3;
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= sums_i.valid;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      part_q <= part_d;
    end
  end

  assign valid_o = valid_q;
  assign part_o  = part_q;

`ifndef SYNTHESIS
  // with the upper sums cleared only partitions zero and one can win
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && sums_i.valid && sums_i.c == '0 && sums_i.d == '0) |=>
    (part_o == 2'd0 || part_o == 2'd1))
    else $error("apsel_pick: upper partition chosen with cleared sums");
`endif

endmodule

// ===== rtl/core/astc_partition_select.sv =====
// top level: texel partition selector, four-stage pipeline
`timescale 1ns / 1ps

//  channel   direction  transaction
//  s_axis    in         one texel: seed, count, x, y, z
//  m_axis    out        partition index of that texel
//  cfg       in         small block mode bit
//
// one texel per clock sustained while the output is not stalled; each result passes the
// registers hash multiply, hash mixing, weighted sums and compare in that order.
// reset clears the valid bits and the mode bit (normal block size).
// a stalled output freezes every stage together, so nothing is lost or repeated;
// the config channel is always ready.

module astc_partition_select (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [9:0] pattern_seed, [12:10] partition_count, [16:13] texel_x,
  // [20:17] texel_y, [24:21] texel_z, [31:25] zero
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] partition, [7:2] zero
  output logic [7:0]  m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);
  import apsel_pkg::*;

  logic             small_mode_q;
  logic             en;
  item_t            item;
  hash_t            hash;
  sums_t            sums;
  logic             out_valid;
  logic [PartW-1:0] part;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      small_mode_q <= cfg_data_i;
    end
  end

  // pipeline advances unless a result is held
  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  // unpack input transaction
  assign item = item_t'(s_axis_tdata[24:0]);

  apsel_hash u_hash (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .in_valid_i   (s_axis_tvalid),
    .in_i         (item),
    .small_mode_i (small_mode_q),
    .out_o        (hash)
  );

  apsel_weigh u_weigh (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .hash_i (hash),
    .sums_o (sums)
  );

  apsel_pick u_pick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .sums_i  (sums),
    .valid_o (out_valid),
    .part_o  (part)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, part};

`ifndef SYNTHESIS
  // an accepted texel reaches the output once each later stage has advanced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 en ##1 en ##1 en |=> m_axis_tvalid)
    else $error("astc_partition_select: transaction lost in pipeline");

  // an output whose weighted sums stage held no transaction is invented
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && !sums.valid) |=> !m_axis_tvalid)
    else $error("astc_partition_select: result without a transaction");

  // the config write lands the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> (small_mode_q == $past(cfg_data_i)))
    else $error("astc_partition_select: mode write not taken");
`endif

endmodule
